// ----- sv/aaec_pkg.sv -----
package aaec_pkg;

	typedef enum logic [2:0] {
		ACT_SAMPLE   = 3'd0,
		ACT_CAP_MIN  = 3'd1,
		ACT_CAP_MAX  = 3'd2,
		ACT_RESTART  = 3'd3,
		ACT_SNAPSHOT = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		REG_RET_MIN  = 2'd0,
		REG_RET_MAX  = 2'd1,
		REG_RELEARN  = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIV_START,
		ST_DIV,
		ST_OUT
	} state_t;

	localparam logic [15:0] SIG_MASK      = 16'h0ffe;
	localparam logic [15:0] PRESENT_LIMIT = 16'h0fc0;
	localparam logic [15:0] SAMPLE_RANGE  = 16'h1000;
	localparam logic [15:0] DEF_MIN       = 16'h0f38;
	localparam logic [15:0] DEF_MAX       = 16'h00c8;
	localparam logic [15:0] MARGIN        = 16'd40;
	localparam logic [16:0] MIN_TRAVEL    = 17'd200;
	localparam logic [15:0] SETTLE_OFFSET = 16'd240;
	localparam logic [31:0] SETTLE_MS     = 32'd2000;

	// controller -> datapath
	typedef struct packed {
		logic load_in;
		logic update;
		logic div_start;
		logic div_step;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_div;
		logic div_last;
	} dp_sts_t;

endpackage

// ----- sv/analog_axis_endpoint_calibrator_unit.sv -----
// Channel | Dir | tdata fields (LSB first)                          | tuser
// s_axis  | in  | action[2:0] raw_sample[14:3] filtered[26:15]      | -
//         |     | automatic_mode[27] time_ms[59:28], zero to 64 bits |
// m_axis  | out | source_active[0] axis_value[8:1] snapshot_valid[9] | -
//         |     | snapshot_minimum[25:10] snapshot_maximum[41:26]    |
//         |     | snapshot_relearn[42], zero to 48 bits              |
// Sequence: accept, update, then, for a scaled byte, a setup step and the bit-serial
// quotient divider over 24 numerator bits, then output.
// Requests: one at a time; a new request is accepted only after the previous result is taken.
// Reset: arst_n clears control; endpoints load their learning defaults.
// A register write reloads endpoints on the following cycle.
// Stalls: result holds in place until m_axis_tready.
module analog_axis_endpoint_calibrator_unit import aaec_pkg::*; #(
	parameter int LEARN_SAMPLES = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // action, raw_sample, filtered_signal, automatic_mode, time_ms
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // source_active, axis_value, snapshot_valid/min/max/relearn
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	aaec_ctrl u_ctrl (
		.clk, .arst_n,
		.in_fire (s_axis_tvalid && s_axis_tready),
		.out_fire(m_axis_tvalid && m_axis_tready),
		.sts, .cmd,
		.in_rdy  (s_axis_tready),
		.out_vld (m_axis_tvalid)
	);

	aaec_dp #(.LEARN_SAMPLES(LEARN_SAMPLES)) u_dp (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data, .cmd,
		.action         (s_axis_tdata[2:0]),
		.raw_sample     (s_axis_tdata[14:3]),
		.filtered_signal(s_axis_tdata[26:15]),
		.automatic_mode (s_axis_tdata[27]),
		.time_ms        (s_axis_tdata[59:28]),
		.sts,
		.res            (m_axis_tdata)
	);

endmodule

// ----- sv/aaec_ctrl.sv -----
module aaec_ctrl import aaec_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_fire,
	input  logic    out_fire,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic    in_rdy,
	output logic    out_vld
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:      if (in_fire) state_nx = ST_UPDATE;
			ST_UPDATE:    state_nx = sts.need_div ? ST_DIV_START : ST_OUT;
			ST_DIV_START: state_nx = ST_DIV;
			ST_DIV:       if (sts.div_last) state_nx = ST_OUT;
			ST_OUT:       if (out_fire) state_nx = ST_IDLE;
			default:      state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.load_in = in_fire;
		in_rdy    = 1'b0;
		out_vld   = 1'b0;
		case (state_q)
			ST_IDLE:      in_rdy = 1'b1;
			ST_UPDATE:    cmd.update = 1'b1;
			ST_DIV_START: cmd.div_start = 1'b1;
			ST_DIV:       cmd.div_step = 1'b1;
			ST_OUT:       out_vld = 1'b1;
			default:      ;
		endcase
	end

endmodule

// ----- sv/aaec_dp.sv -----
module aaec_dp import aaec_pkg::*; #(
	parameter int LEARN_SAMPLES = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	input  dp_cmd_t     cmd,
	input  logic [2:0]  action,
	input  logic [11:0] raw_sample,
	input  logic [11:0] filtered_signal,
	input  logic        automatic_mode,
	input  logic [31:0] time_ms,
	output dp_sts_t     sts,
	output logic [47:0] res
);

	localparam logic [3:0] LEARN_N = 4'(LEARN_SAMPLES);

	logic [15:0] ret_min_q, ret_max_q;
	logic        relearn_q;
	logic [15:0] min_ep_q, max_ep_q, cand_q, settle_lvl_q;
	logic [31:0] deadline_q;
	logic [3:0]  lcnt_q;
	logic        f_uninit_q, f_armed_q, f_learn_q, f_settle_q, f_minp_q, f_maxp_q, f_chg_q;

	logic [2:0]  act_q;
	logic [15:0] s_q;
	logic        active_q, autom_q;
	logic [31:0] now_q;

	// result fields
	logic        r_active_q, r_snap_q, r_relearn_q;
	logic [7:0]  r_axis_q;
	logic [15:0] r_min_q, r_max_q;
	logic        need_div_q;

	// serial divider
	logic [15:0] dvs_q;
	logic [23:0] rem_q;
	logic [23:0] num_q;
	logic [7:0]  quo_q;

	// next-state of calibration for a sample
	logic [15:0] n_min, n_max, n_cand, n_lvl;
	logic [31:0] n_dl, n_diff;
	logic [3:0]  n_cnt;
	logic        n_un, n_ar, n_le, n_se, n_mp, n_xp, n_ch;

	always_comb begin
		n_min = min_ep_q; n_max = max_ep_q; n_cand = cand_q; n_lvl = settle_lvl_q;
		n_dl = deadline_q; n_cnt = lcnt_q; n_diff = '0;
		n_un = f_uninit_q; n_ar = f_armed_q; n_le = f_learn_q; n_se = f_settle_q;
		n_mp = f_minp_q; n_xp = f_maxp_q; n_ch = f_chg_q;
		if (autom_q) begin
			if (n_le || s_q <= n_lvl) begin
				n_se = 1'b0;
			end else begin
				if (!n_se) begin
					n_dl = now_q + SETTLE_MS;
					n_se = 1'b1;
				end
				// deadline reached when the wrapped difference is not negative
				n_diff = now_q - n_dl;
				if (!n_diff[31]) begin
					n_max = s_q - MARGIN;
					n_lvl = s_q - MARGIN;
					n_se = 1'b0;
					n_un = 1'b0;
					n_ch = 1'b1;
				end
			end
		end else begin
			if (n_xp) begin
				if ({1'b0, s_q} > {1'b0, n_min} + MIN_TRAVEL) begin
					n_max = s_q - MARGIN;
					n_un = 1'b0;
				end
				n_xp = 1'b0;
			end
			if (n_mp) begin
				n_min = s_q + MARGIN;
				n_mp = 1'b0;
			end
		end
		if (n_un) begin
			if (n_le && n_cnt < LEARN_N) begin
				n_cnt = n_cnt + 4'd1;
				if (s_q < n_cand) n_cand = s_q;
				if (n_cnt == LEARN_N) begin
					n_min = n_cand + MARGIN;
					n_lvl = n_cand + SETTLE_OFFSET;
					n_le = 1'b0;
					n_cnt = 4'd0;
				end
			end
			if (!(s_q <= n_max || {1'b0, s_q} <= {1'b0, n_min} + MIN_TRAVEL)) begin
				if (autom_q) begin
					if (n_ar) begin
						n_ar = 1'b0;
						n_max = s_q;
					end
				end else begin
					n_ar = 1'b1;
					n_max = s_q;
				end
			end
		end
	end

	logic [15:0] sig;
	logic        start_learn;
	logic        cfg_we_d_q;
	assign sig = {4'd0, ~raw_sample} & SIG_MASK;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			act_q    <= action;
			s_q      <= SAMPLE_RANGE - {4'd0, filtered_signal};
			active_q <= (sig <= PRESENT_LIMIT);
			autom_q  <= automatic_mode;
			now_q    <= time_ms;
		end
	end

	assign start_learn = relearn_q || ret_min_q >= ret_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_we_d_q <= 1'b0;
		end else begin
			cfg_we_d_q <= cfg_we && cfg_idx <= REG_RELEARN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_min_q <= DEF_MIN; ret_max_q <= DEF_MAX; relearn_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_RET_MIN: ret_min_q <= cfg_data;
				REG_RET_MAX: ret_max_q <= cfg_data;
				REG_RELEARN: relearn_q <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_ep_q <= DEF_MIN; max_ep_q <= DEF_MAX; cand_q <= DEF_MIN;
			settle_lvl_q <= '0; deadline_q <= '0; lcnt_q <= '0;
			f_uninit_q <= 1'b1; f_armed_q <= 1'b1; f_learn_q <= 1'b1; f_settle_q <= 1'b0;
			f_minp_q <= 1'b0; f_maxp_q <= 1'b0; f_chg_q <= 1'b1;
		end else if (cfg_we_d_q) begin
			// start load follows any register write, using the new values next cycle
			min_ep_q <= start_learn ? DEF_MIN : ret_min_q;
			max_ep_q <= start_learn ? DEF_MAX : ret_max_q;
			cand_q <= start_learn ? DEF_MIN : 16'd0;
			settle_lvl_q <= '0; deadline_q <= '0; lcnt_q <= '0;
			f_uninit_q <= start_learn; f_armed_q <= start_learn; f_learn_q <= start_learn;
			f_settle_q <= 1'b0; f_minp_q <= 1'b0; f_maxp_q <= 1'b0; f_chg_q <= start_learn;
		end else if (cmd.update) begin
			case (act_q)
				ACT_SAMPLE: if (active_q) begin
					min_ep_q <= n_min; max_ep_q <= n_max; cand_q <= n_cand;
					settle_lvl_q <= n_lvl; deadline_q <= n_dl; lcnt_q <= n_cnt;
					f_uninit_q <= n_un; f_armed_q <= n_ar; f_learn_q <= n_le;
					f_settle_q <= n_se; f_minp_q <= n_mp; f_maxp_q <= n_xp; f_chg_q <= n_ch;
				end
				ACT_CAP_MIN: begin f_minp_q <= 1'b1; f_chg_q <= 1'b1; end
				ACT_CAP_MAX: begin f_maxp_q <= 1'b1; f_chg_q <= 1'b1; end
				ACT_RESTART: begin
					cand_q <= DEF_MIN; min_ep_q <= DEF_MIN; max_ep_q <= DEF_MAX;
					deadline_q <= '0; lcnt_q <= '0;
					f_uninit_q <= 1'b1; f_armed_q <= 1'b1; f_learn_q <= 1'b1;
					f_settle_q <= 1'b0; f_minp_q <= 1'b0; f_maxp_q <= 1'b0; f_chg_q <= 1'b1;
				end
				ACT_SNAPSHOT: f_chg_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// results and scaling setup, from post-update state
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			r_active_q <= 1'b0; r_axis_q <= '0; r_snap_q <= 1'b0;
			r_min_q <= '0; r_max_q <= '0; r_relearn_q <= 1'b0; need_div_q <= 1'b0;
			case (act_q)
				ACT_SAMPLE: if (active_q) begin
					r_active_q <= 1'b1;
					if (s_q <= n_min || n_max <= n_min) r_axis_q <= '0;
					else if (s_q >= n_max) r_axis_q <= 8'd255;
					else begin
						need_div_q <= 1'b1;
						num_q <= {({8'd0, s_q - n_min} << 8) - {8'd0, s_q - n_min}};
						dvs_q <= n_max - n_min;
					end
				end
				ACT_SNAPSHOT: if (f_chg_q) begin
					r_snap_q <= 1'b1; r_min_q <= min_ep_q; r_max_q <= max_ep_q;
					r_relearn_q <= autom_q;
				end
				default: ;
			endcase
		end else if (cmd.div_start) begin
			rem_q <= '0; quo_q <= '0;
		end else if (cmd.div_step) begin
			// quotient < 256: restoring division, one bit per cycle over 24 numerator bits
			if ({rem_q[22:0], num_q[23]} >= {8'd0, dvs_q}) begin
				rem_q <= {rem_q[22:0], num_q[23]} - {8'd0, dvs_q};
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				rem_q <= {rem_q[22:0], num_q[23]};
				quo_q <= {quo_q[6:0], 1'b0};
			end
			num_q <= {num_q[22:0], 1'b0};
		end
	end

	// last step count: 24 bits at one per cycle needs a 5-bit counter
	logic [4:0] dstep_q;
	always_ff @(posedge clk) begin
		if (cmd.div_start) dstep_q <= '0;
		else if (cmd.div_step) dstep_q <= dstep_q + 5'd1;
	end

	// decided from the update-cycle values, ahead of need_div_q
	assign sts.need_div = (act_q == ACT_SAMPLE) && active_q && (s_q > n_min)
		&& (n_max > n_min) && (s_q < n_max);
	assign sts.div_last = cmd.div_step && dstep_q == 5'd23;

	assign res = {5'd0, r_relearn_q, r_max_q, r_min_q, r_snap_q,
		(need_div_q ? quo_q : r_axis_q), r_active_q};

endmodule

// ----- sv/aaec_checker.sv -----
module aaec_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [47:0] m_axis_tdata
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("busy overlap");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_inact: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
		else $error("inactive axis nonzero");
endmodule

bind analog_axis_endpoint_calibrator_unit aaec_checker u_chk (.*);
